@@ hdl/sct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants of the shell command tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [3:0] TC_NONE     = 4'd0;
	localparam logic [3:0] TC_SEP      = 4'd1;
	localparam logic [3:0] TC_PIPE     = 4'd2;
	localparam logic [3:0] TC_DAEMON   = 4'd3;
	localparam logic [3:0] TC_SPLIT    = 4'd4;
	localparam logic [3:0] TC_COMMENT  = 4'd5;
	localparam logic [3:0] TC_REDIRECT = 4'd6;
	localparam logic [3:0] TC_SINGLE   = 4'd7;
	localparam logic [3:0] TC_DOUBLE   = 4'd8;
	localparam logic [3:0] TC_WORD     = 4'd9;

	typedef enum logic [3:0] {
		K_ZERO,
		K_SPACE,
		K_SEMI,
		K_PIPE,
		K_AMP,
		K_BSL,
		K_HASH,
		K_LT,
		K_GT,
		K_SQUOTE,
		K_DQUOTE,
		K_OTHER
	} char_kind_t;

	typedef struct packed {
		logic [7:0] data;
		char_kind_t kind;
	} sct_item_t;

endpackage
`default_nettype wire

@@ hdl/sct_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_front
// Accepts input bytes and tags each with its character kind.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire logic [7:0] s_tdata,   // in_byte[7:0]
	output logic           item_valid,
	input  wire logic      item_ready,
	output sct_item_t      item
);

	logic       valid_s1;
	sct_item_t  item_s1;
	char_kind_t kind;

	always_comb begin
		case (s_tdata) inside
			CH_NUL:              kind = K_ZERO;
			[8'd1:CH_SPACE]:     kind = K_SPACE;
			CH_SEMI:             kind = K_SEMI;
			CH_PIPE:             kind = K_PIPE;
			CH_AMP:              kind = K_AMP;
			CH_BSL:              kind = K_BSL;
			CH_HASH:             kind = K_HASH;
			CH_LT:               kind = K_LT;
			CH_GT:               kind = K_GT;
			CH_SQUOTE:           kind = K_SQUOTE;
			CH_DQUOTE:           kind = K_DQUOTE;
			default:             kind = K_OTHER;
		endcase
	end

	assign s_tready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data <= s_tdata;
			item_s1.kind <= kind;
		end
	end

endmodule
`default_nettype wire

@@ hdl/sct_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module sct_queue import sct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_ready,
	input  wire sct_item_t push_item,
	output logic           pop_valid,
	input  wire logic      pop_ready,
	output sct_item_t      pop_item
);

	sct_item_t         entry_q [Q_DEPTH];
	logic [Q_AW-1:0]   wptr_q;
	logic [Q_AW-1:0]   rptr_q;
	logic [Q_AW:0]     count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ hdl/sct_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_back
// Lexer state machine; turns tagged bytes into registered token results.
// ----------------------------------------------------------------------------
module sct_back import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire sct_item_t   item,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // out_char[7:0], token_class[11:8], token_start[12],
	                                   // separated_before[13], quote_open[14],
	                                   // drop_backslash[15]
	output logic             m_tlast   // line_end
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_WORD,
		M_COMMENT,
		M_GT,
		M_SQ,
		M_DQ,
		M_DQESC
	} mode_t;

	mode_t      mode_q, mode_n, idle_mode;
	logic       space_q, space_n, idle_space;
	logic [3:0] idle_cls, cls;
	logic       idle_start, idle_sep;
	logic       start, sep, lend, qopen, drop, special;
	logic [7:0] ochar;
	logic       take;

	logic       valid_q;
	logic [7:0] char_q;
	logic [3:0] cls_q;
	logic       start_q, sep_q, lend_q, qopen_q, drop_q;

	assign item_ready = !valid_q || m_tready;
	assign take       = item_valid && item_ready;

	assign special = item.kind inside {K_SEMI, K_PIPE, K_AMP, K_BSL, K_LT, K_GT,
		K_SQUOTE, K_DQUOTE};

	always_comb begin
		idle_cls   = TC_NONE;
		idle_start = 1'b0;
		idle_sep   = 1'b0;
		idle_space = 1'b0;
		idle_mode  = M_IDLE;
		if (item.kind == K_SPACE || item.kind == K_ZERO) begin
			idle_space = 1'b1;
		end else begin
			idle_start = 1'b1;
			idle_sep   = space_q;
			case (item.kind)
				K_SEMI:   idle_cls = TC_SEP;
				K_PIPE:   idle_cls = TC_PIPE;
				K_AMP:    idle_cls = TC_DAEMON;
				K_BSL:    idle_cls = TC_SPLIT;
				K_HASH: begin
					idle_cls  = TC_COMMENT;
					idle_mode = M_COMMENT;
				end
				K_LT:     idle_cls = TC_REDIRECT;
				K_GT: begin
					idle_cls  = TC_REDIRECT;
					idle_mode = M_GT;
				end
				K_SQUOTE: begin
					idle_cls  = TC_SINGLE;
					idle_mode = M_SQ;
				end
				K_DQUOTE: begin
					idle_cls  = TC_DOUBLE;
					idle_mode = M_DQ;
				end
				default: begin
					idle_cls  = TC_WORD;
					idle_mode = M_WORD;
				end
			endcase
		end
	end

	always_comb begin
		ochar   = item.data;
		cls     = TC_NONE;
		start   = 1'b0;
		sep     = 1'b0;
		lend    = 1'b0;
		qopen   = 1'b0;
		drop    = 1'b0;
		mode_n  = mode_q;
		space_n = space_q;
		if (item.kind == K_ZERO) begin
			lend  = 1'b1;
			ochar = CH_NUL;
			if (mode_q == M_SQ || mode_q == M_DQ || mode_q == M_DQESC) begin
				qopen = 1'b1;
				cls   = (mode_q == M_SQ) ? TC_SINGLE : TC_DOUBLE;
				if (mode_q == M_DQESC) begin
					drop   = 1'b1;
					mode_n = M_DQ;
				end else begin
					ochar = CH_NL;
				end
			end else begin
				mode_n  = M_IDLE;
				space_n = 1'b0;
			end
		end else begin
			case (mode_q)
				M_WORD: begin
					if (item.kind != K_SPACE && !special) begin
						cls = TC_WORD;
					end else begin
						cls     = idle_cls;
						start   = idle_start;
						sep     = idle_sep;
						space_n = idle_space;
						mode_n  = idle_mode;
					end
				end
				M_COMMENT: cls = TC_COMMENT;
				M_GT: begin
					if (item.kind == K_GT) begin
						cls    = TC_REDIRECT;
						mode_n = M_IDLE;
					end else begin
						cls     = idle_cls;
						start   = idle_start;
						sep     = idle_sep;
						space_n = idle_space;
						mode_n  = idle_mode;
					end
				end
				M_SQ: begin
					cls = TC_SINGLE;
					if (item.kind == K_SQUOTE) begin
						mode_n = M_IDLE;
					end
				end
				M_DQ: begin
					cls = TC_DOUBLE;
					if (item.kind == K_BSL) begin
						mode_n = M_DQESC;
					end else if (item.kind == K_DQUOTE) begin
						mode_n = M_IDLE;
					end
				end
				M_DQESC: begin
					cls    = TC_DOUBLE;
					mode_n = M_DQ;
				end
				default: begin
					cls     = idle_cls;
					start   = idle_start;
					sep     = idle_sep;
					space_n = idle_space;
					mode_n  = idle_mode;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			space_q <= 1'b0;
			valid_q <= 1'b0;
			char_q  <= '0;
			cls_q   <= TC_NONE;
			start_q <= 1'b0;
			sep_q   <= 1'b0;
			lend_q  <= 1'b0;
			qopen_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (item_ready) begin
			valid_q <= item_valid;
			if (take) begin
				mode_q  <= mode_n;
				space_q <= space_n;
				char_q  <= ochar;
				cls_q   <= cls;
				start_q <= start;
				sep_q   <= sep;
				lend_q  <= lend;
				qopen_q <= qopen;
				drop_q  <= drop;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {drop_q, qopen_q, sep_q, start_q, cls_q, char_q};
	assign m_tlast  = lend_q;

endmodule
`default_nettype wire

@@ hdl/shell_command_tokenizer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shell_command_tokenizer_core
// Byte-serial shell command-line tokenizer.
// ----------------------------------------------------------------------------
// One byte enters per transaction on the slave side, a zero byte ending the
// line; one result leaves per byte on the master side, tlast marking the
// result of the zero byte. The block sustains one byte per clock while the
// master side does not stall: the front register classifies the byte, a
// four-entry queue buffers it, and the lexer state machine in the back updates
// its mode and loads the output register in the same cycle. A stalled master
// side fills the queue before the slave side stops.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_core import sct_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // in_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // out_char[7:0], token_class[11:8], token_start[12],
	                                   // separated_before[13], quote_open[14],
	                                   // drop_backslash[15]
	output logic             m_tlast   // line_end
);

	logic      f_valid, f_ready;
	sct_item_t f_item;
	logic      b_valid, b_ready;
	sct_item_t b_item;

	sct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	sct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	sct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
`default_nettype wire

@@ hdl/sct_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
module sct_checker import sct_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_line_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !m_tdata[14] && !m_tdata[15])
		else $error("quote or drop flag outside line end");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[15] |->
			m_tdata[14] && m_tdata[7:0] == CH_NUL && m_tdata[11:8] == TC_DOUBLE)
		else $error("backslash drop outside open double quote");

	a_sep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[12] |-> !m_tdata[13])
		else $error("separation flag without token start");

	a_plain_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tdata[14] |->
			m_tdata[11:8] == TC_NONE && m_tdata[7:0] == CH_NUL && !m_tdata[12])
		else $error("unquoted line end carries a token");

endmodule

bind shell_command_tokenizer_core sct_checker u_sct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

@@ tb/shell_command_tokenizer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_command_tokenizer_core_test
// Self-checking testbench of the shell command tokenizer core.
// ----------------------------------------------------------------------------
// Command lines are streamed byte by byte into the slave side. The lines are
// mostly well-formed: words, operators, '>>', quoted strings with escapes,
// comments, and quotes left open across line ends. Noise lines of raw bytes
// are mixed in. A behavioral lexer predicts the result of every accepted byte,
// and each result on the master side is compared field by field with the
// oldest prediction. Both sides idle at random, the receiver once holds off
// long enough to back up the input, and the sender drains between phases.
// ----------------------------------------------------------------------------
module shell_command_tokenizer_core_test;
	import sct_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int LONG_HOLD   = 64;
	localparam int TAIL_CYCLES = 12;
	localparam int DRAIN_MARK  = -1;

	typedef enum logic [2:0] {
		LX_IDLE,
		LX_WORD,
		LX_COMMENT,
		LX_GT,
		LX_SQ,
		LX_DQ,
		LX_DQESC
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] cls;
		logic       start;
		logic       sep;
		logic       lend;
		logic       qopen;
		logic       drop;
	} token_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;

	lex_mode_t     lx_mode       = LX_IDLE;
	logic          lx_space      = 1'b0;
	logic          lx_cont_quote = 1'b0;
	int            line_bytes[$];
	token_result_t predicted_tokens[$];
	int            bytes_queued     = 0;
	int            items_sent       = 0;
	int            results_seen     = 0;
	int            field_errors     = 0;
	int            lines_ended      = 0;
	int            quotes_carried   = 0;
	int            backslash_drops  = 0;
	int            tx_gap_max       = 0;
	int            rx_stall_max     = 0;
	int            tx_gap_left      = 0;
	int            rx_stall_left    = 0;
	int            rx_hold_left     = 0;
	int            holds_requested  = 0;
	int            holds_served     = 0;
	int            idle_cycles      = 0;

	shell_command_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic is_operator_char(input logic [7:0] b);
		return b inside {CH_LT, CH_GT, CH_SEMI, CH_PIPE, CH_BSL, CH_AMP, CH_SQUOTE,
			CH_DQUOTE};
	endfunction

	function automatic void lex_from_idle(input logic [7:0] b, inout token_result_t r);
		if (b <= CH_SPACE) begin
			lx_space = 1'b1;
			lx_mode  = LX_IDLE;
			r.cls    = TC_NONE;
		end else begin
			r.start  = 1'b1;
			r.sep    = lx_space;
			lx_space = 1'b0;
			lx_mode  = LX_IDLE;
			case (b)
				CH_SEMI:  r.cls = TC_SEP;
				CH_PIPE:  r.cls = TC_PIPE;
				CH_AMP:   r.cls = TC_DAEMON;
				CH_BSL:   r.cls = TC_SPLIT;
				CH_LT:    r.cls = TC_REDIRECT;
				CH_HASH: begin
					r.cls   = TC_COMMENT;
					lx_mode = LX_COMMENT;
				end
				CH_GT: begin
					r.cls   = TC_REDIRECT;
					lx_mode = LX_GT;
				end
				CH_SQUOTE: begin
					r.cls         = TC_SINGLE;
					lx_mode       = LX_SQ;
					lx_cont_quote = 1'b0;
				end
				CH_DQUOTE: begin
					r.cls         = TC_DOUBLE;
					lx_mode       = LX_DQ;
					lx_cont_quote = 1'b0;
				end
				default: begin
					r.cls   = TC_WORD;
					lx_mode = LX_WORD;
				end
			endcase
		end
	endfunction

	function automatic token_result_t lex_byte(input logic [7:0] b);
		token_result_t r;
		r    = '0;
		r.ch = b;
		if (b == CH_NUL) begin
			r.lend = 1'b1;
			lines_ended++;
			if (lx_mode inside {LX_SQ, LX_DQ, LX_DQESC}) begin
				r.qopen       = 1'b1;
				lx_cont_quote = 1'b1;
				quotes_carried++;
				r.cls = (lx_mode == LX_SQ) ? TC_SINGLE : TC_DOUBLE;
				if (lx_mode == LX_DQESC) begin
					r.drop  = 1'b1;
					lx_mode = LX_DQ;
					backslash_drops++;
				end else begin
					r.ch = CH_NL;
				end
			end else begin
				lx_mode  = LX_IDLE;
				lx_space = 1'b0;
			end
		end else begin
			case (lx_mode)
				LX_WORD: begin
					if (b > CH_SPACE && !is_operator_char(b))
						r.cls = TC_WORD;
					else
						lex_from_idle(b, r);
				end
				LX_COMMENT: r.cls = TC_COMMENT;
				LX_GT: begin
					if (b == CH_GT) begin
						r.cls   = TC_REDIRECT;
						lx_mode = LX_IDLE;
					end else begin
						lex_from_idle(b, r);
					end
				end
				LX_SQ: begin
					r.cls = TC_SINGLE;
					if (b == CH_SQUOTE) begin
						lx_mode       = LX_IDLE;
						lx_cont_quote = 1'b0;
					end
				end
				LX_DQ: begin
					r.cls = TC_DOUBLE;
					if (b == CH_BSL) begin
						lx_mode = LX_DQESC;
					end else if (b == CH_DQUOTE) begin
						lx_mode       = LX_IDLE;
						lx_cont_quote = 1'b0;
					end
				end
				LX_DQESC: begin
					r.cls   = TC_DOUBLE;
					lx_mode = LX_DQ;
				end
				default: lex_from_idle(b, r);
			endcase
		end
		return r;
	endfunction

	task automatic report_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		field_errors++;
	endtask

	task automatic check_result(input token_result_t want);
		token_result_t got;
		got = '{ch: m_tdata[7:0], cls: m_tdata[11:8], start: m_tdata[12],
			sep: m_tdata[13], lend: m_tlast, qopen: m_tdata[14], drop: m_tdata[15]};
		if (got.ch !== want.ch)
			report_field("out_char", want.ch, got.ch);
		if (got.cls !== want.cls)
			report_field("token_class", 8'(want.cls), 8'(got.cls));
		if (got.start !== want.start)
			report_field("token_start", 8'(want.start), 8'(got.start));
		if (got.sep !== want.sep)
			report_field("separated_before", 8'(want.sep), 8'(got.sep));
		if (got.lend !== want.lend)
			report_field("line_end", 8'(want.lend), 8'(got.lend));
		if (got.qopen !== want.qopen)
			report_field("quote_open", 8'(want.qopen), 8'(got.qopen));
		if (got.drop !== want.drop)
			report_field("drop_backslash", 8'(want.drop), 8'(got.drop));
	endtask

	task automatic queue_byte(input logic [7:0] b);
		line_bytes.push_back(int'(b));
		bytes_queued++;
	endtask

	task automatic queue_quote(input logic [7:0] q);
		int n;
		int pick;
		logic [7:0] b;
		queue_byte(q);
		n = $urandom_range(0, 6);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				queue_byte(CH_NUL);
			end else if (q == CH_DQUOTE && pick == 1) begin
				queue_byte(CH_BSL);
				queue_byte(CH_NUL);
			end else if (q == CH_DQUOTE && pick == 2) begin
				queue_byte(CH_BSL);
				queue_byte(8'($urandom_range(1, 255)));
			end else begin
				do
					b = 8'($urandom_range(1, 255));
				while (b == q || (q == CH_DQUOTE && b == CH_BSL));
				queue_byte(b);
			end
		end
		if ($urandom_range(0, 7) != 0)
			queue_byte(q);
	endtask

	task automatic queue_line();
		logic [7:0] ops [6] = '{CH_SEMI, CH_PIPE, CH_AMP, CH_BSL, CH_LT, CH_GT};
		int ntok;
		int n;
		logic [7:0] b;
		ntok = $urandom_range(1, 8);
		for (int k = 0; k < ntok; k++) begin
			if ($urandom_range(0, 1) != 0)
				queue_byte(CH_SPACE);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					n = $urandom_range(1, 6);
					repeat (n) begin
						do
							b = 8'($urandom_range(33, 255));
						while (is_operator_char(b));
						queue_byte(b);
					end
				end
				3: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(1, 32)));
				4: queue_byte(ops[$urandom_range(0, 5)]);
				5: begin
					queue_byte(CH_GT);
					queue_byte(CH_GT);
				end
				6: queue_quote(CH_SQUOTE);
				7: queue_quote(CH_DQUOTE);
				8: begin
					queue_byte(CH_HASH);
					repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range(1, 255)));
					k = ntok;
				end
				default: queue_byte(8'($urandom_range(1, 255)));
			endcase
		end
		queue_byte(CH_NUL);
	endtask

	task automatic queue_random(input int n);
		int first;
		first = bytes_queued;
		while (bytes_queued - first < n) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12)) queue_byte(8'($urandom_range(0, 255)));
				queue_byte(CH_NUL);
			end else begin
				queue_line();
			end
		end
	endtask

	task automatic finish_phase();
		line_bytes.push_back(DRAIN_MARK);
		while (line_bytes.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid      <= 1'b0;
			s_tdata       <= 8'h00;
			tx_gap_left   = 0;
			lx_mode       = LX_IDLE;
			lx_space      = 1'b0;
			lx_cont_quote = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted_tokens.push_back(lex_byte(s_tdata));
				items_sent <= items_sent + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap_left > 0) begin
					tx_gap_left--;
					s_tvalid <= 1'b0;
				end else if (line_bytes.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (line_bytes[0] == DRAIN_MARK) begin
					if (items_sent == results_seen && !(s_tvalid && s_tready))
						void'(line_bytes.pop_front());
					s_tvalid <= 1'b0;
				end else begin
					s_tdata     <= 8'(line_bytes.pop_front());
					s_tvalid    <= 1'b1;
					tx_gap_left = $urandom_range(0, tx_gap_max);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready      <= 1'b0;
			rx_stall_left = 0;
			rx_hold_left  = 0;
			holds_served  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (predicted_tokens.size() == 0) begin
					$display("%0t: result %h last %b arrived with nothing expected",
						$time, m_tdata, m_tlast);
					field_errors++;
				end else begin
					check_result(predicted_tokens.pop_front());
				end
				rx_stall_left = $urandom_range(0, rx_stall_max);
			end
			if (holds_served != holds_requested) begin
				holds_served++;
				rx_hold_left = LONG_HOLD;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				m_tready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d of %0d results seen",
				$time, IDLE_LIMIT, results_seen, items_sent);
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [7:0] directed[$] = '{8'h61, CH_HASH, 8'hFF, 8'h01, CH_GT, CH_GT, 8'h78,
			CH_SPACE, CH_LT, CH_SEMI, CH_PIPE, CH_AMP, CH_BSL, CH_GT, 8'h21, CH_HASH,
			8'h80, CH_NUL, CH_SQUOTE, 8'h71, CH_NUL, CH_SQUOTE, CH_DQUOTE, CH_BSL,
			CH_NUL, CH_DQUOTE, CH_DQUOTE, CH_NUL, CH_DQUOTE, CH_NUL};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			queue_byte(directed[i]);
		finish_phase();

		// back up the input behind a long receiver hold
		tx_gap_max   = 0;
		rx_stall_max = 16;
		holds_requested++;
		queue_random(400);
		finish_phase();

		tx_gap_max   = 16;
		rx_stall_max = 0;
		queue_random(400);
		finish_phase();

		tx_gap_max   = 16;
		rx_stall_max = 16;
		queue_random(400);
		finish_phase();

		tx_gap_max   = 0;
		rx_stall_max = 0;
		queue_random(300);
		finish_phase();

		while (line_bytes.size() != 0 || s_tvalid || items_sent != results_seen)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Streamed %0d bytes over %0d lines: %0d open quotes, %0d backslash drops",
			items_sent, lines_ended, quotes_carried, backslash_drops);
		$display("Checked %0d results, %0d field errors", results_seen, field_errors);
		if (field_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
